>>> rtl/core/a7s_pkg.sv
// shared types, constants and the seven-segment font for the ascii to seven-segment stream
`default_nettype none

package a7s_pkg;

    localparam logic [2:0] MAX_DIGITS  = 3'd4;
    localparam logic [7:0] DOT_CHAR    = 8'h2E;
    localparam logic [7:0] DASH_CHAR   = 8'h2D;
    localparam logic [7:0] DP_BIT      = 8'h80;
    localparam logic [7:0] DASH_SEG    = 8'h40;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int         CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] DIGIT_FONT [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    localparam logic [7:0] UPPER_FONT [26] = '{
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h79, 8'h76, 8'h06, 8'h1E,
        8'h76, 8'h38, 8'h76, 8'h76, 8'h3F, 8'h73, 8'h6F, 8'h76, 8'h79, 8'h78,
        8'h3E, 8'h3E, 8'h3E, 8'h76, 8'h6E, 8'h5B
    };

    localparam logic [7:0] LOWER_FONT [26] = '{
        8'h77, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F, 8'h74, 8'h10, 8'h1E,
        8'h74, 8'h18, 8'h74, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h1C, 8'h1C, 8'h26, 8'h76, 8'h6E, 8'h53
    };

    typedef struct packed {
        logic [7:0] digit_address;
        logic [7:0] segments;
        logic       write;
        logic       end_of_string;
    } t_result;

    typedef struct packed {
        logic    en0;
        logic    en1;
        t_result e0;
        t_result e1;
    } t_push;

    function automatic logic [7:0] font_lookup(input logic [7:0] c);
        logic [7:0] seg;
        seg = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            seg = DIGIT_FONT[4'(c - 8'h30)];
        end else if (c inside {[8'h41:8'h5A]}) begin
            seg = UPPER_FONT[5'(c - 8'h41)];
        end else if (c inside {[8'h61:8'h7A]}) begin
            seg = LOWER_FONT[5'(c - 8'h61)];
        end else if (c == DASH_CHAR) begin
            seg = DASH_SEG;
        end else if (c == DOT_CHAR) begin
            seg = DP_BIT;
        end
        return seg;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/a7s_if.sv
// valid/ready channel interfaces for characters in and digit results out
`default_nettype none

interface a7s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic [7:0] grid_base;
    logic       last_char;

    modport source (output valid, output char_code, output grid_base, output last_char,
                    input ready);
    modport sink   (input valid, input char_code, input grid_base, input last_char,
                    output ready);
endinterface

interface a7s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_address;
    logic [7:0] segments;
    logic       write;
    logic       end_of_string;

    modport source (output valid, output digit_address, output segments, output write,
                    output end_of_string, input ready);
    modport sink   (input valid, input digit_address, input segments, input write,
                    input end_of_string, output ready);
endinterface

`default_nettype wire

>>> rtl/core/a7s_front.sv
// front end: accepts characters, tracks the held digit and position, emits up to two results
`default_nettype none

module a7s_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    a7s_in_if.sink              i_in,
    input  wire logic           i_room,
    output a7s_pkg::t_push      o_push
);
    import a7s_pkg::*;

    logic       r_held_valid;
    logic [7:0] r_held_segments;
    logic [2:0] r_digit_count;
    logic       n_held_valid;
    logic [7:0] n_held_segments;
    logic [2:0] n_digit_count;

    logic       accept;
    logic       is_dot;
    logic       a_ok;
    logic       b_ok;
    logic [2:0] cnt1;
    logic [7:0] cur_seg;
    t_result    res_a;
    t_result    res_b;
    t_result    res_empty;

    assign i_in.ready = i_room;
    assign accept     = i_in.valid & i_room;

    always_comb begin
        cur_seg = font_lookup(i_in.char_code);
        is_dot  = r_held_valid && (i_in.char_code == DOT_CHAR);
        a_ok    = r_held_valid && (r_digit_count < MAX_DIGITS);
        cnt1    = r_digit_count + {2'b00, a_ok};
        b_ok    = !is_dot && i_in.last_char && (cnt1 < MAX_DIGITS);

        res_a.digit_address = i_in.grid_base + {5'b00000, r_digit_count};
        res_a.segments      = is_dot ? (r_held_segments | DP_BIT) : r_held_segments;
        res_a.write         = 1'b1;
        res_a.end_of_string = i_in.last_char && !b_ok;

        res_b.digit_address = i_in.grid_base + {5'b00000, cnt1};
        res_b.segments      = cur_seg;
        res_b.write         = 1'b1;
        res_b.end_of_string = i_in.last_char;

        res_empty.digit_address = 8'h00;
        res_empty.segments      = 8'h00;
        res_empty.write         = 1'b0;
        res_empty.end_of_string = 1'b1;

        o_push.en0 = accept && (a_ok || b_ok || i_in.last_char);
        o_push.en1 = accept && a_ok && b_ok;
        o_push.e0  = a_ok ? res_a : (b_ok ? res_b : res_empty);
        o_push.e1  = res_b;

        n_held_valid    = r_held_valid;
        n_held_segments = r_held_segments;
        n_digit_count   = r_digit_count;
        if (accept) begin
            if (i_in.last_char) begin
                n_held_valid    = 1'b0;
                n_held_segments = 8'h00;
                n_digit_count   = 3'd0;
            end else if (is_dot) begin
                n_held_valid  = 1'b0;
                n_digit_count = cnt1;
            end else begin
                n_held_valid    = 1'b1;
                n_held_segments = cur_seg;
                n_digit_count   = cnt1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid    <= 1'b0;
            r_held_segments <= 8'h00;
            r_digit_count   <= 3'd0;
        end else begin
            r_held_valid    <= n_held_valid;
            r_held_segments <= n_held_segments;
            r_digit_count   <= n_digit_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_count <= MAX_DIGITS)
        else $error("digit count beyond display size");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last_char) |=> (!r_held_valid && r_digit_count == 3'd0))
        else $error("state not cleared after last character");
`endif

endmodule

`default_nettype wire

>>> rtl/core/a7s_queue.sv
// short result queue between front and back, up to two writes and one read per cycle
`default_nettype none

module a7s_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire a7s_pkg::t_push i_push,
    input  wire logic           i_pop,
    output logic                o_room,
    output logic                o_valid,
    output a7s_pkg::t_result    o_head
);
    import a7s_pkg::*;

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic [PTR_W-1:0]   wr_ptr1;
    logic               do_pop;

    assign o_room  = r_count <= CNT_W'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.en0) + PTR_W'(i_push.en1);
        n_rd_ptr = r_rd_ptr + PTR_W'(do_pop);
        n_count  = r_count + CNT_W'(i_push.en0) + CNT_W'(i_push.en1) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.en0) begin
            r_mem[r_wr_ptr] <= i_push.e0;
        end
        if (i_push.en1) begin
            r_mem[wr_ptr1] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.en0 |-> o_room)
        else $error("queue written without room");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.en1 |-> i_push.en0)
        else $error("second entry pushed without first");
`endif

endmodule

`default_nettype wire

>>> rtl/core/a7s_back.sv
// back end: drains the queue into the output register
`default_nettype none

module a7s_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire a7s_pkg::t_result i_head,
    output logic                  o_pop,
    a7s_out_if.source             o_out
);
    import a7s_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_pop = i_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.digit_address = r_data.digit_address;
    assign o_out.segments      = r_data.segments;
    assign o_out.write         = r_data.write;
    assign o_out.end_of_string = r_data.end_of_string;

endmodule

`default_nettype wire

>>> rtl/core/ascii_to_seven_segment_stream_top.sv
// top level of the ascii to seven-segment digit stream encoder
// usage:
//   i_in carries one character per item with its grid base and a last-character flag.
//   o_out carries digit results: address, segment byte, write flag, end_of_string.
//   a character is held one item so a following '.' can set its decimal point;
//   at most four digits per string are written, the rest dropped.
//   the last character flushes the held digit; with no digit left a single
//   result with write low and end_of_string high closes the string.
// timing:
//   a result is written into the queue when its item is accepted and then moves
//   into the output register, from which it is valid on o_out; the second
//   result of a pair follows it out of the queue.
//   one item can be taken every cycle while the queue has room for two results;
//   the output side delivers one result per cycle while o_out.ready is high, so
//   a string that produces one result per character streams at one item per
//   cycle, and a last character may produce two results.
// reset and stall:
//   synchronous active-low reset empties the queue and output register and
//   clears the held digit and position; i_in.ready is low only while the
//   four-entry queue lacks room for two results, as when o_out.ready stays low.
`default_nettype none

module ascii_to_seven_segment_stream_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    a7s_in_if.sink      i_in,
    a7s_out_if.source   o_out
);
    import a7s_pkg::*;

    t_push   push;
    t_result head;
    logic    room;
    logic    q_valid;
    logic    pop;

    a7s_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    a7s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_valid (q_valid),
        .o_head  (head)
    );

    a7s_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
